FILE: src/imu_tilt_angle_estimator_macros.svh
// Assertion macros for the tilt angle estimator.
`ifndef IMU_TILT_ANGLE_ESTIMATOR_MACROS_SVH
`define IMU_TILT_ANGLE_ESTIMATOR_MACROS_SVH
`ifndef SYNTHESIS
`define ITAE_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ITAE_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ITAE_ASSERT_IMP(label, clk, rst_n, a, c)
`define ITAE_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: src/itae_pkg.sv
// Shared types, constants and the arctangent table of the tilt estimator.
package itae_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int STEP_W = $clog2(NSTEPS + 1);
  // datapath: 16 bit input * 256, grows by about 1.65 over the steps
  localparam int XY_W = 27;
  localparam int Z_W = 25;
  localparam int ACC_W = 40;
  localparam int ANGLE_LIMIT = 46080;
  localparam logic [ACC_W-1:0] ACC_PRESET = ACC_W'(64'd90 * 256 * 65536);

  localparam logic [1:0] REG_OFF_X = 2'd0;
  localparam logic [1:0] REG_OFF_Y = 2'd1;
  localparam logic [1:0] REG_OFF_Z = 2'd2;
  localparam logic [1:0] REG_GAIN  = 2'd3;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  // lane control from the sequencer
  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] idx;
  } lane_ctl_t;

  function automatic logic signed [Z_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    case (i)
      0: atan_step = 25'sd2949120;  1: atan_step = 25'sd1740967;
      2: atan_step = 25'sd919879;   3: atan_step = 25'sd466945;
      4: atan_step = 25'sd234379;   5: atan_step = 25'sd117304;
      6: atan_step = 25'sd58666;    7: atan_step = 25'sd29335;
      8: atan_step = 25'sd14668;    9: atan_step = 25'sd7334;
      10: atan_step = 25'sd3667;    11: atan_step = 25'sd1833;
      12: atan_step = 25'sd917;     13: atan_step = 25'sd458;
      14: atan_step = 25'sd229;     15: atan_step = 25'sd115;
      16: atan_step = 25'sd57;      17: atan_step = 25'sd29;
      18: atan_step = 25'sd14;      19: atan_step = 25'sd7;
      20: atan_step = 25'sd4;       21: atan_step = 25'sd2;
      22: atan_step = 25'sd1;
      default: atan_step = '0;
    endcase
  endfunction
endpackage

FILE: src/imu_tilt_angle_estimator.sv
// Top level of the IMU tilt angle estimator.
// One beat in gives one beat out: three accelerometer angles from three
// parallel CORDIC lanes and three gyro-integrated angles, all in 1/256
// degree. An item is accepted in the idle state, runs 16 CORDIC steps
// (one step per cycle in each lane) and is then held as the result;
// a new item is taken only after the result has been taken.
module imu_tilt_angle_estimator import itae_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_gyro_x,
  input  logic signed [15:0] in_gyro_y,
  input  logic signed [15:0] in_gyro_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_accel_pitch,
  output logic signed [16:0] out_accel_yaw,
  output logic signed [16:0] out_accel_roll,
  output logic signed [23:0] out_rate_pitch,
  output logic signed [23:0] out_rate_yaw,
  output logic signed [23:0] out_rate_roll,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  lane_ctl_t   ctl;
  logic        first;
  logic [15:0] off_x_r, off_y_r, off_z_r, gain_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0; off_y_r <= '0; off_z_r <= '0; gain_r <= 16'd20480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFF_X: off_x_r <= cfg_data;
        REG_OFF_Y: off_y_r <= cfg_data;
        REG_OFF_Z: off_z_r <= cfg_data;
        REG_GAIN:  gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  itae_seq u_seq (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
                  .ctl, .first);

  itae_cordic_lane u_pitch (.clk, .ctl, .y_in(in_accel_z), .x_in(in_accel_y),
                            .angle(out_accel_pitch));
  itae_cordic_lane u_yaw (.clk, .ctl, .y_in(in_accel_y), .x_in(in_accel_x),
                          .angle(out_accel_yaw));
  itae_cordic_lane u_roll (.clk, .ctl, .y_in(in_accel_x), .x_in(in_accel_z),
                           .angle(out_accel_roll));

  itae_gyro_lane u_gp (.clk, .rst_n, .ctl, .first, .negate(1'b1), .rate(in_gyro_x),
                       .offset(off_x_r), .gain(gain_r), .angle(out_rate_pitch));
  itae_gyro_lane u_gy (.clk, .rst_n, .ctl, .first, .negate(1'b0), .rate(in_gyro_y),
                       .offset(off_y_r), .gain(gain_r), .angle(out_rate_yaw));
  itae_gyro_lane u_gr (.clk, .rst_n, .ctl, .first, .negate(1'b0), .rate(in_gyro_z),
                       .offset(off_z_r), .gain(gain_r), .angle(out_rate_roll));
endmodule

FILE: src/itae_cordic_lane.sv
// One vectoring CORDIC lane: atan2(y, x) one step per cycle.
module itae_cordic_lane import itae_pkg::*; (
  input  logic                    clk,
  input  lane_ctl_t               ctl,
  input  logic signed [15:0]      y_in,
  input  logic signed [15:0]      x_in,
  output logic signed [16:0]      angle
);
  logic signed [XY_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic                   zero_r, zero_nxt;
  logic signed [XY_W-1:0] xs, ys, x0, y0;
  logic signed [Z_W-1:0]  zr;

  // shifted terms; >>> floors
  assign xs = x_r >>> ctl.idx;
  assign ys = y_r >>> ctl.idx;

  always_comb begin
    x0 = XY_W'(x_in) <<< 8;
    y0 = XY_W'(y_in) <<< 8;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; zero_nxt = zero_r;
    if (ctl.load) begin
      zero_nxt = (x_in == 0) && (y_in == 0);
      x_nxt = x0; y_nxt = y0; z_nxt = '0;
      // pre-rotate into the right half plane
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_nxt = y0; y_nxt = -x0; z_nxt = 25'sd5898240;
        end else begin
          x_nxt = -y0; y_nxt = x0; z_nxt = -25'sd5898240;
        end
      end
    end else if (ctl.step) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + atan_step(ctl.idx);
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - atan_step(ctl.idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; zero_r <= zero_nxt;
  end

  // round half up to 1/256 degree and clamp
  always_comb begin
    zr = (z_r + Z_W'(128)) >>> 8;
    if (zero_r) angle = '0;
    else if (zr > Z_W'(ANGLE_LIMIT)) angle = 17'(ANGLE_LIMIT);
    else if (zr < -Z_W'(ANGLE_LIMIT)) angle = -17'(ANGLE_LIMIT);
    else angle = 17'(zr);
  end
endmodule

FILE: src/itae_gyro_lane.sv
// Gyro integration lane: add offset, scale by gain, saturating accumulate.
module itae_gyro_lane import itae_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctl_t          ctl,
  input  logic               first,
  input  logic               negate,
  input  logic signed [15:0] rate,
  input  logic signed [15:0] offset,
  input  logic [15:0]        gain,
  output logic signed [23:0] angle
);
  logic signed [16:0]      sum_r, sum_nxt;
  logic signed [33:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W+1:0] wide;
  logic                    fst_r;

  assign sum_nxt = 17'(rate) + 17'(offset);

  // load captures the sum, step 0 multiplies, step 1 accumulates
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum_r <= sum_nxt; fst_r <= first;
    end
    if (ctl.step && ctl.idx == 0) prod_r <= 34'(sum_r) * $signed({1'b0, gain});
  end

  always_comb begin
    wide = negate ? (42'(acc_r) - 42'(prod_r)) : (42'(acc_r) + 42'(prod_r));
    if (fst_r) acc_nxt = ACC_PRESET;
    else if (wide > 42'sh7F_FFFF_FFFF) acc_nxt = {1'b0, {(ACC_W-1){1'b1}}};
    else if (wide < -42'sh80_0000_0000) acc_nxt = {1'b1, {(ACC_W-1){1'b0}}};
    else acc_nxt = ACC_W'(wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= '0;
    else if (ctl.step && ctl.idx == STEP_W'(1)) acc_r <= acc_nxt;
  end

  assign angle = acc_r[39:16];
endmodule

FILE: src/itae_seq.sv
// Sequencer: accepts a beat, steps the lanes, holds the result beat.
module itae_seq import itae_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output lane_ctl_t ctl,
  output logic      first
);
  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              first_r, first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; first_r <= 1'b1;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; first_r <= first_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; first_nxt = first_r;
    ctl = '{load: 1'b0, step: 1'b0, idx: cnt_r};
    in_stall = 1'b1; out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load = 1'b1; state_nxt = ST_RUN; cnt_nxt = '0;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(NSTEPS - 1)) begin
          state_nxt = ST_DONE; first_nxt = 1'b0;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign first = first_r;

  `include "imu_tilt_angle_estimator_macros.svh"
  `ITAE_ASSERT_IMP(a_load_idle, clk, rst_n, ctl.load, state_r == ST_IDLE)
  `ITAE_ASSERT_NXT(a_run_after_load, clk, rst_n, ctl.load, state_r == ST_RUN && cnt_r == 0)
  `ITAE_ASSERT_IMP(a_no_valid_while_open, clk, rst_n, out_valid, in_stall)
endmodule
